// ----- design/distance_filtered_cell_sorter_macros.svh -----
// Assertion macros used by the distance filtered cell sorter top level.
`ifndef DISTANCE_FILTERED_CELL_SORTER_MACROS_SVH
`define DISTANCE_FILTERED_CELL_SORTER_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define DFCS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("distance_filtered_cell_sorter: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define DFCS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("distance_filtered_cell_sorter: next-cycle check failed");

`endif

// ----- design/dfcs_pkg.sv -----
// Shared types, constants and helper functions of the distance filtered cell sorter.
package dfcs_pkg;

	localparam int MAX_RULES = 8;
	localparam int MAX_CELLS = 64;
	localparam int RIDX_W    = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
	localparam int RCNT_W    = $clog2(MAX_RULES + 1);
	localparam int CIDX_W    = $clog2(MAX_CELLS);
	localparam int CCNT_W    = $clog2(MAX_CELLS + 1);

	// Operation codes carried by an input word.
	typedef enum logic [1:0] {
		OP_RULE   = 2'd0,
		OP_CELL   = 2'd1,
		OP_FINISH = 2'd2
	} op_e;

	// Control states of the top level.
	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} state_e;

	// One input word.
	typedef struct packed {
		logic [1:0]         operation;
		logic signed [15:0] coord_x;
		logic signed [15:0] coord_y;
		logic [16:0]        min_distance;
	} item_t;

	// One result word.
	typedef struct packed {
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic               cell_valid;
		logic               last_cell;
		logic               overflow;
	} result_t;

	// A grid cell as held in the sorting chain.
	typedef struct packed {
		logic signed [15:0] y;
		logic signed [15:0] x;
	} cell_t;

	// An exclusion rule.
	typedef struct packed {
		logic signed [15:0] cx;
		logic signed [15:0] cy;
		logic [16:0]        dmin;
	} rule_t;

	// Commands from the control logic to the sorting chain.
	typedef struct packed {
		logic  insert;
		logic  shift;
		cell_t data;
	} chain_ctl_t;

	// True when cell a belongs strictly ahead of cell b: by y, then by x.
	function automatic logic cell_before(cell_t a, cell_t b);
		logic res;
		if (a.y != b.y) begin
			res = (a.y < b.y);
		end else begin
			res = (a.x < b.x);
		end
		return res;
	endfunction

endpackage

// ----- design/dfcs_rules.sv -----
// Exclusion rule store with one Manhattan distance check per rule, all in parallel.
module dfcs_rules (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           clear,
	input  logic           load,
	input  dfcs_pkg::rule_t new_rule,
	input  dfcs_pkg::cell_t probe,
	output logic           allowed,
	output logic           full
);
	import dfcs_pkg::*;

	rule_t              rule_q [MAX_RULES];
	logic [RCNT_W-1:0]  count_q;
	logic [MAX_RULES-1:0] hit;

	assign full = (count_q == RCNT_W'(MAX_RULES));

	// Rule entries are written in arrival order at the fill count.
	always_ff @(posedge clk) begin
		if (load && !full) begin
			rule_q[count_q[RIDX_W-1:0]] <= new_rule;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (clear) begin
			count_q <= '0;
		end else if (load && !full) begin
			count_q <= count_q + RCNT_W'(1);
		end
	end

	// Each stored rule flags the probe if it lies closer than the rule's minimum.
	for (genvar i = 0; i < MAX_RULES; i++) begin : g_rule
		logic signed [16:0] dx;
		logic signed [16:0] dy;
		logic [15:0]        ax;
		logic [15:0]        ay;
		logic [16:0]        mdist;

		always_comb begin
			dx = {probe.x[15], probe.x} - {rule_q[i].cx[15], rule_q[i].cx};
			dy = {probe.y[15], probe.y} - {rule_q[i].cy[15], rule_q[i].cy};
			ax = dx[16] ? 16'(-dx) : dx[15:0];
			ay = dy[16] ? 16'(-dy) : dy[15:0];
			mdist = {1'b0, ax} + {1'b0, ay};
			hit[i] = (RCNT_W'(i) < count_q) && (mdist < rule_q[i].dmin);
		end
	end

	assign allowed = ~|hit;

endmodule

// ----- design/dfcs_cell.sv -----
// One cell of the sorting chain: holds one grid cell and trades with its neighbors.
module dfcs_cell (
	input  logic                       clk,
	input  dfcs_pkg::chain_ctl_t       ctl,
	input  logic [dfcs_pkg::CIDX_W-1:0] idx,
	input  logic [dfcs_pkg::CCNT_W-1:0] fill,
	input  dfcs_pkg::cell_t            prev_data,
	input  logic                       prev_ins,
	input  dfcs_pkg::cell_t            next_data,
	output dfcs_pkg::cell_t            data,
	output logic                       ins
);
	import dfcs_pkg::*;

	cell_t data_q;

	// The new cell goes at or ahead of this slot if the slot is empty or holds a later cell.
	assign ins  = (CCNT_W'(idx) >= fill) || cell_before(ctl.data, data_q);
	assign data = data_q;

	// On insert, the slot at the insertion point takes the new cell and slots behind it take
	// their left neighbor's cell; on shift, every slot takes its right neighbor's cell.
	always_ff @(posedge clk) begin
		if (ctl.insert && ins) begin
			data_q <= prev_ins ? prev_data : ctl.data;
		end else if (ctl.shift) begin
			data_q <= next_data;
		end
	end

endmodule

// ----- design/dfcs_chain.sv -----
// Row of sorting cells with its fill count; the head cell is the smallest.
module dfcs_chain (
	input  logic                        clk,
	input  logic                        arst_n,
	input  dfcs_pkg::chain_ctl_t        ctl,
	output dfcs_pkg::cell_t             head,
	output logic [dfcs_pkg::CCNT_W-1:0] fill
);
	import dfcs_pkg::*;

	cell_t             data_w [MAX_CELLS];
	logic              ins_w  [MAX_CELLS];
	logic [CCNT_W-1:0] fill_q;

	// Number of occupied slots, counted from the head.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctl.insert) begin
			fill_q <= fill_q + CCNT_W'(1);
		end else if (ctl.shift) begin
			fill_q <= fill_q - CCNT_W'(1);
		end
	end

	assign fill = fill_q;
	assign head = data_w[0];

	// The cells, each wired to its two neighbors.
	for (genvar i = 0; i < MAX_CELLS; i++) begin : g_cell
		cell_t prev_data;
		logic  prev_ins;
		cell_t next_data;

		if (i == 0) begin : g_first
			assign prev_data = ctl.data;
			assign prev_ins  = 1'b0;
		end else begin : g_mid
			assign prev_data = data_w[i-1];
			assign prev_ins  = ins_w[i-1];
		end

		if (i == MAX_CELLS - 1) begin : g_last
			assign next_data = '0;
		end else begin : g_inner
			assign next_data = data_w[i+1];
		end

		dfcs_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.idx       (CIDX_W'(i)),
			.fill      (fill_q),
			.prev_data (prev_data),
			.prev_ins  (prev_ins),
			.next_data (next_data),
			.data      (data_w[i]),
			.ins       (ins_w[i])
		);
	end

endmodule

// ----- design/distance_filtered_cell_sorter.sv -----
// Top level of the distance filtered cell sorter: control, filter stage and result register.
//
// Rule and cell words are taken one per cycle while the input is not stalled: a word
// first passes a filter stage, where all stored rules are checked against a cell in
// parallel, and a kept cell is inserted into a chain of 64 sorting cells in the next
// cycle, each cell deciding locally whether to keep its entry, take its neighbor's or
// take the new one. A finish word stalls the input while it sits in the filter stage,
// then the sorted cells leave the head of the chain one word per cycle while the
// result side does not stall; the input stays stalled until the last word has been
// loaded into the result register (an empty batch yields a single word with
// cell_valid low). Overflow is reported on every word of the batch.
`include "distance_filtered_cell_sorter_macros.svh"

module distance_filtered_cell_sorter (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  dfcs_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_stall,
	output dfcs_pkg::result_t result
);
	import dfcs_pkg::*;

	state_e            state_q;
	state_e            state_d;
	logic              vld_s1;
	item_t             item_s1;
	logic              ins_s2;
	cell_t             cell_s2;
	logic [CCNT_W-1:0] cell_count_q;
	logic              ovf_q;
	logic              emit_ovf_q;
	logic              emit_empty_q;
	logic              res_valid_q;
	result_t           result_q;

	logic              accept;
	logic              rule_load;
	logic              cell_offer;
	logic              fin;
	logic              allowed;
	logic              rules_full;
	logic              cells_full;
	logic              keep;
	logic              set_ovf;
	logic              slot_free;
	logic              take_head;
	logic              load_empty;
	cell_t             probe;
	rule_t             new_rule;
	chain_ctl_t        chain_ctl;
	cell_t             head;
	logic [CCNT_W-1:0] fill;

	// Input handshake: hold off during emission and behind a pending finish.
	assign item_stall = (state_q == ST_EMIT) || (vld_s1 && (item_s1.operation == OP_FINISH));
	assign accept     = item_valid && !item_stall;

	// Filter stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
	end

	// Decode of the word in the filter stage.
	always_comb begin
		rule_load  = 1'b0;
		cell_offer = 1'b0;
		fin        = 1'b0;
		case (op_e'(item_s1.operation))
			OP_RULE:   rule_load  = vld_s1;
			OP_CELL:   cell_offer = vld_s1;
			OP_FINISH: fin        = vld_s1;
			default:   ;
		endcase
	end

	assign probe      = '{y: item_s1.coord_y, x: item_s1.coord_x};
	assign new_rule   = '{cx: item_s1.coord_x, cy: item_s1.coord_y,
		dmin: item_s1.min_distance};
	assign cells_full = (cell_count_q == CCNT_W'(MAX_CELLS));
	assign keep       = cell_offer && allowed && !cells_full;
	assign set_ovf    = (rule_load && rules_full) || (cell_offer && allowed && cells_full);

	dfcs_rules u_rules (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (fin),
		.load     (rule_load),
		.new_rule (new_rule),
		.probe    (probe),
		.allowed  (allowed),
		.full     (rules_full)
	);

	// Batch bookkeeping; a finish snapshots it for the emitted words and clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_count_q <= '0;
			ovf_q        <= 1'b0;
			emit_ovf_q   <= 1'b0;
			emit_empty_q <= 1'b0;
			ins_s2       <= 1'b0;
		end else begin
			ins_s2 <= keep;
			if (fin) begin
				cell_count_q <= '0;
				ovf_q        <= 1'b0;
				emit_ovf_q   <= ovf_q;
				emit_empty_q <= (cell_count_q == '0);
			end else begin
				if (keep) begin
					cell_count_q <= cell_count_q + CCNT_W'(1);
				end
				if (set_ovf) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	// Insertion stage register.
	always_ff @(posedge clk) begin
		if (keep) begin
			cell_s2 <= probe;
		end
	end

	assign chain_ctl = '{insert: ins_s2, shift: take_head, data: cell_s2};

	dfcs_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (chain_ctl),
		.head   (head),
		.fill   (fill)
	);

	// Control state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and emission control.
	assign slot_free = !res_valid_q || !result_stall;

	always_comb begin
		state_d    = state_q;
		take_head  = 1'b0;
		load_empty = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (fin) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (slot_free) begin
					if (emit_empty_q) begin
						load_empty = 1'b1;
						state_d    = ST_IDLE;
					end else begin
						take_head = 1'b1;
						if (fill == CCNT_W'(1)) begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Result register between the chain head and the result channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take_head || load_empty) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_head) begin
			result_q <= '{out_x: head.x, out_y: head.y, cell_valid: 1'b1,
				last_cell: (fill == CCNT_W'(1)), overflow: emit_ovf_q};
		end else if (load_empty) begin
			result_q <= '{out_x: '0, out_y: '0, cell_valid: 1'b0,
				last_cell: 1'b1, overflow: emit_ovf_q};
		end
	end

	assign result_valid = res_valid_q;
	assign result       = result_q;

	// Design checks.
	`DFCS_ASSERT_IMP(a_stall_in_emit, state_q == ST_EMIT, item_stall)
	`DFCS_ASSERT_IMP(a_empty_is_last, result_valid && !result.cell_valid, result.last_cell)
	`DFCS_ASSERT_IMP(a_fill_tracks_count, state_q == ST_IDLE && !ins_s2, fill == cell_count_q)
	`DFCS_ASSERT_NXT(a_last_ends_emit, take_head && fill == CCNT_W'(1), state_q == ST_IDLE)

endmodule
